// ----- sv/corner_fillet_circle_unit_assert.svh -----
// ----------------------------------------------------------------------------
// corner fillet circle unit assertion macros
// implication checks used by the fillet circle datapath
// ----------------------------------------------------------------------------
`ifndef CORNER_FILLET_CIRCLE_UNIT_ASSERT_SVH
`define CORNER_FILLET_CIRCLE_UNIT_ASSERT_SVH

// same-cycle implication
`define CFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cfc_pkg.sv -----
// ----------------------------------------------------------------------------
// cfc_pkg
// widths, pipeline depths and carry types of the fillet circle unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfc_pkg;

    localparam int ONE30     = 1 << 30;
    localparam int VEC_W     = 34;            // ray difference or bisector sum
    localparam int NMAG_W    = 31;            // normalized magnitude
    localparam int SUM_W     = 64;            // sum of squares
    localparam int USQ_LAT   = SUM_W / 2;     // root stages inside a normalizer
    localparam int UQ_W      = 31;            // unit component quotient bits
    localparam int UNIT_LAT  = 6 + USQ_LAT + UQ_W + 1;
    localparam int MAG_DLY   = USQ_LAT + 2;
    localparam int FLG_DLY   = UNIT_LAT - 3;
    localparam int DEN_W     = 62;            // 2^60 - ca^2, padded to even width
    localparam int SD_W      = DEN_W / 2;
    localparam int NUM_W     = 61;            // offset numerator magnitude
    localparam int OQ_W      = 34;            // offset quotient bits before clamping
    localparam int LAT       = 1 + UNIT_LAT + 1 + UNIT_LAT + 5 + SD_W + 1 + OQ_W + 2;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [30:0]      r;
    } t_car_a;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [30:0]      r;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic             dg;
    } t_car_b;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [30:0]      r;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [2:0][31:0] m;
        logic             dg;
    } t_car_m;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [30:0]      r;
        logic [2:0][31:0] m;
        logic [2:0][31:0] pa;
        logic [2:0][31:0] pb;
        logic             dg;
    } t_car_c;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [8:0]       neg;
        logic             dg;
    } t_car_d;

endpackage

// ----- sv/cfc_isqrt.sv -----
// ----------------------------------------------------------------------------
// cfc_isqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfc_isqrt #(
    parameter int IW = 64
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [IW-1:0]     i_x,
    output logic [IW/2-1:0]   o_root
);

    localparam int OW = IW / 2;
    localparam int RW = IW + 1;

    logic [RW-1:0] r_rem  [OW];
    logic [OW-1:0] r_root [OW];

    for (genvar k = 0; k < OW; k++) begin : g_stage
        localparam int B = OW - 1 - k;
        logic [RW-1:0] rem_in;
        logic [OW-1:0] root_in;
        logic [RW-1:0] trial;

        if (k == 0) begin : g_head
            assign rem_in  = {1'b0, i_x};
            assign root_in = '0;
        end else begin : g_body
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // (q + 2^b)^2 - q^2
        assign trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[k]  <= rem_in - trial;
                    r_root[k] <= root_in | (OW'(1) << B);
                end else begin
                    r_rem[k]  <= rem_in;
                    r_root[k] <= root_in;
                end
            end
        end
    end

    assign o_root = r_root[OW-1];

endmodule

// ----- sv/cfc_div.sv -----
// ----------------------------------------------------------------------------
// cfc_div
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfc_div #(
    parameter int NW = 61,
    parameter int DW = 32,
    parameter int QW = 31
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int HW = NW - QW;

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [QW-1:0] r_low [QW];
    logic [DW-1:0] r_den [QW];
    logic          r_ovf [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [QW-1:0] low_in;
        logic          ovf_in;
        logic [DW:0]   trial;
        logic          take;

        if (j == 0) begin : g_head
            assign rem_in = {{(DW-HW){1'b0}}, i_num[NW-1:QW]};
            assign den_in = i_den;
            assign quo_in = '0;
            assign low_in = i_num[QW-1:0];
            // quotient would not fit in qw bits
            assign ovf_in = {{(DW-HW){1'b0}}, i_num[NW-1:QW]} >= i_den;
        end else begin : g_body
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
            assign low_in = r_low[j-1];
            assign ovf_in = r_ovf[j-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                r_quo[j] <= {quo_in[QW-2:0], take};
                r_low[j] <= {low_in[QW-2:0], 1'b0};
                r_den[j] <= den_in;
                r_ovf[j] <= ovf_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_ovf = r_ovf[QW-1];

endmodule

// ----- sv/corner_fillet_circle_unit.sv -----
// ----------------------------------------------------------------------------
// corner_fillet_circle_unit
// throughput: one transaction per cycle while the output is not stalled; every square root and divider is
//   unrolled one result bit per register stage, so nothing is shared
// a stalled output freezes the whole pipeline, nothing is dropped
// reset clears the valid bits only; datapath registers are not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "corner_fillet_circle_unit_assert.svh"

module corner_fillet_circle_unit
    import cfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_corner_x,
    input  logic [31:0] i_corner_y,
    input  logic [31:0] i_corner_z,
    input  logic [31:0] i_first_x,
    input  logic [31:0] i_first_y,
    input  logic [31:0] i_first_z,
    input  logic [31:0] i_second_x,
    input  logic [31:0] i_second_y,
    input  logic [31:0] i_second_z,
    input  logic [30:0] i_circle_radius,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_centre_x,
    output logic [31:0] o_centre_y,
    output logic [31:0] o_centre_z,
    output logic [31:0] o_touch_first_x,
    output logic [31:0] o_touch_first_y,
    output logic [31:0] o_touch_first_z,
    output logic [31:0] o_touch_second_x,
    output logic [31:0] o_touch_second_y,
    output logic [31:0] o_touch_second_z,
    output logic        o_degenerate
);

    // dot product in q4.60 down to q2.30, truncated toward zero, clamped to +-1
    function automatic logic signed [31:0] f_trunc30(input logic signed [63:0] d);
        logic [63:0] mag;
        logic [33:0] q;
        logic [31:0] qc;
        mag = d[63] ? 64'(-d) : 64'(d);
        q   = mag[63:30];
        qc  = (q > 34'(ONE30)) ? 32'(ONE30) : q[31:0];
        return d[63] ? -$signed(qc) : $signed(qc);
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [36:0] v);
        if (v > 37'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -37'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic [30:0] f_abs31(input logic [31:0] v);
        return v[31] ? 31'(-$signed(v)) : v[30:0];
    endfunction

    // ------------------------------------------------------------------------
    // flow control: the whole pipeline advances whenever the output slot
    // is free or being emptied in this cycle
    // ------------------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    logic [31:0] in_c [3];
    logic [31:0] in_f [3];
    logic [31:0] in_s [3];

    assign in_c = '{i_corner_x, i_corner_y, i_corner_z};
    assign in_f = '{i_first_x, i_first_y, i_first_z};
    assign in_s = '{i_second_x, i_second_y, i_second_z};

    // ------------------------------------------------------------------------
    // stage 1: ray differences, exact in 34 bits
    // ------------------------------------------------------------------------
    logic signed [VEC_W-1:0] r_s1_da [3];
    logic signed [VEC_W-1:0] r_s1_db [3];
    t_car_a                  r_s1_car;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_da[i] <= $signed({{2{in_f[i][31]}}, in_f[i]})
                            - $signed({{2{in_c[i][31]}}, in_c[i]});
                r_s1_db[i] <= $signed({{2{in_s[i][31]}}, in_s[i]})
                            - $signed({{2{in_c[i][31]}}, in_c[i]});
                r_s1_car.c[i] <= in_c[i];
            end
            r_s1_car.r <= i_circle_radius;
        end
    end

    // ------------------------------------------------------------------------
    // three vector normalizers: first ray, second ray, bisector
    // magnitude, scale into [2^30, 2^31), root of sum of squares, divide
    // ------------------------------------------------------------------------
    logic signed [VEC_W-1:0] unit_vin  [3][3];
    logic [31:0]             unit_u    [3][3];
    logic                    unit_zero [3];
    logic signed [VEC_W-1:0] r_ss_s    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unit_vin[0][i] = r_s1_da[i];
            unit_vin[1][i] = r_s1_db[i];
            unit_vin[2][i] = r_ss_s[i];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_unit
        logic [32:0]       r_u1_mag  [3];
        logic [2:0]        r_u1_neg;
        logic [32:0]       r_u2_mag  [3];
        logic [32:0]       r_u2_mx;
        logic [2:0]        r_u2_neg;
        logic              r_u2_zero;
        logic [32:0]       r_u3_mag  [3];
        logic [5:0]        r_u3_pos;
        logic [NMAG_W-1:0] r_u4_nmag [3];
        logic [61:0]       r_u5_sq   [3];
        logic [SUM_W-1:0]  r_u6_sum;
        logic [NMAG_W-1:0] r_mdly    [MAG_DLY][3];
        logic [3:0]        r_fdly    [FLG_DLY];
        logic [31:0]       r_uf_u    [3];
        logic              r_uf_zero;
        logic [32:0]       n_mx;
        logic [5:0]        n_pos;
        logic [USQ_LAT-1:0] norm;
        logic [UQ_W-1:0]   quo [3];
        logic [2:0]        ovf;

        always_comb begin
            n_mx = r_u1_mag[0];
            if (r_u1_mag[1] > n_mx) begin
                n_mx = r_u1_mag[1];
            end
            if (r_u1_mag[2] > n_mx) begin
                n_mx = r_u1_mag[2];
            end
        end

        // leading one of the largest magnitude
        always_comb begin
            n_pos = '0;
            for (int b = 0; b < 33; b++) begin
                if (r_u2_mx[b]) begin
                    n_pos = 6'(b);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    r_u1_mag[i] <= unit_vin[g][i][VEC_W-1] ? 33'(-unit_vin[g][i])
                                                           : unit_vin[g][i][32:0];
                    r_u1_neg[i] <= unit_vin[g][i][VEC_W-1];
                    r_u2_mag[i] <= r_u1_mag[i];
                    r_u3_mag[i] <= r_u2_mag[i];
                    if (r_u3_pos > 6'd30) begin
                        r_u4_nmag[i] <= NMAG_W'(r_u3_mag[i] >> (r_u3_pos - 6'd30));
                    end else begin
                        r_u4_nmag[i] <= NMAG_W'(r_u3_mag[i] << (6'd30 - r_u3_pos));
                    end
                    r_u5_sq[i] <= 62'(r_u4_nmag[i]) * 62'(r_u4_nmag[i]);
                end
                r_u2_mx   <= n_mx;
                r_u2_neg  <= r_u1_neg;
                r_u2_zero <= ~|(r_u1_mag[0] | r_u1_mag[1] | r_u1_mag[2]);
                r_u3_pos  <= n_pos;
                r_u6_sum  <= SUM_W'(r_u5_sq[0]) + SUM_W'(r_u5_sq[1]) + SUM_W'(r_u5_sq[2]);
            end
        end

        cfc_isqrt #(
            .IW (SUM_W)
        ) u_isqrt (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_x    (r_u6_sum),
            .o_root (norm)
        );

        // magnitudes and signs wait alongside the root and the divide
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mdly[0] <= r_u4_nmag;
                for (int k = 1; k < MAG_DLY; k++) begin
                    r_mdly[k] <= r_mdly[k-1];
                end
                r_fdly[0] <= {r_u2_zero, r_u2_neg};
                for (int k = 1; k < FLG_DLY; k++) begin
                    r_fdly[k] <= r_fdly[k-1];
                end
            end
        end

        for (genvar i = 0; i < 3; i++) begin : g_comp
            cfc_div #(
                .NW (NMAG_W + 30),
                .DW (USQ_LAT),
                .QW (UQ_W)
            ) u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num ({r_mdly[MAG_DLY-1][i], 30'd0}),
                .i_den (norm),
                .o_quo (quo[i]),
                .o_ovf (ovf[i])
            );
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (ovf[i] || quo[i] > UQ_W'(ONE30)) begin
                        r_uf_u[i] <= r_fdly[FLG_DLY-1][i] ? -32'(ONE30) : 32'(ONE30);
                    end else begin
                        r_uf_u[i] <= r_fdly[FLG_DLY-1][i] ? -32'(quo[i]) : 32'(quo[i]);
                    end
                end
                r_uf_zero <= r_fdly[FLG_DLY-1][3];
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                unit_u[g][i] = r_uf_u[i];
            end
            unit_zero[g] = r_uf_zero;
        end
    end

    // ------------------------------------------------------------------------
    // corner and radius ride along the ray normalizers
    // ------------------------------------------------------------------------
    t_car_a r_dla [UNIT_LAT];
    t_car_b r_ss_car;
    t_car_b r_dlb [UNIT_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dla[0] <= r_s1_car;
            for (int k = 1; k < UNIT_LAT; k++) begin
                r_dla[k] <= r_dla[k-1];
            end
            // bisector direction a + b
            for (int i = 0; i < 3; i++) begin
                r_ss_s[i] <= $signed({{2{unit_u[0][i][31]}}, unit_u[0][i]})
                           + $signed({{2{unit_u[1][i][31]}}, unit_u[1][i]});
                r_ss_car.a[i] <= unit_u[0][i];
                r_ss_car.b[i] <= unit_u[1][i];
            end
            r_ss_car.c  <= r_dla[UNIT_LAT-1].c;
            r_ss_car.r  <= r_dla[UNIT_LAT-1].r;
            r_ss_car.dg <= unit_zero[0] | unit_zero[1];
            r_dlb[0] <= r_ss_car;
            for (int k = 1; k < UNIT_LAT; k++) begin
                r_dlb[k] <= r_dlb[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // cosines ca = a.m and cb = b.m, den = 1 - ca^2, projected offsets
    // products are signed 32 x 32, sign-extended into the 64-bit target
    // ------------------------------------------------------------------------
    logic signed [63:0] r_d1_am [3];
    logic signed [63:0] r_d1_bm [3];
    t_car_m             r_d1_car;
    logic signed [63:0] r_d2_da;
    logic signed [63:0] r_d2_db;
    t_car_m             r_d2_car;
    logic signed [31:0] r_d3_ca;
    logic signed [31:0] r_d3_cb;
    t_car_m             r_d3_car;
    logic signed [63:0] r_d4_sq;
    logic signed [63:0] r_d4_pa [3];
    logic signed [63:0] r_d4_pb [3];
    t_car_m             r_d4_car;
    logic [DEN_W-1:0]   r_d5_den;
    t_car_c             r_d5_car;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_d1_am[i] <= $signed(unit_u[2][i]) * $signed(r_dlb[UNIT_LAT-1].a[i]);
                r_d1_bm[i] <= $signed(unit_u[2][i]) * $signed(r_dlb[UNIT_LAT-1].b[i]);
                r_d1_car.m[i] <= unit_u[2][i];
            end
            r_d1_car.c  <= r_dlb[UNIT_LAT-1].c;
            r_d1_car.r  <= r_dlb[UNIT_LAT-1].r;
            r_d1_car.a  <= r_dlb[UNIT_LAT-1].a;
            r_d1_car.b  <= r_dlb[UNIT_LAT-1].b;
            r_d1_car.dg <= r_dlb[UNIT_LAT-1].dg | unit_zero[2];

            r_d2_da  <= r_d1_am[0] + r_d1_am[1] + r_d1_am[2];
            r_d2_db  <= r_d1_bm[0] + r_d1_bm[1] + r_d1_bm[2];
            r_d2_car <= r_d1_car;

            r_d3_ca  <= f_trunc30(r_d2_da);
            r_d3_cb  <= f_trunc30(r_d2_db);
            r_d3_car <= r_d2_car;

            r_d4_sq <= r_d3_ca * r_d3_ca;
            for (int i = 0; i < 3; i++) begin
                r_d4_pa[i] <= $signed(r_d3_car.a[i]) * r_d3_ca;
                r_d4_pb[i] <= $signed(r_d3_car.b[i]) * r_d3_cb;
            end
            r_d4_car <= r_d3_car;

            r_d5_den <= (DEN_W'(1) << 60) - r_d4_sq[DEN_W-1:0];
            for (int i = 0; i < 3; i++) begin
                r_d5_car.pa[i] <= f_trunc30(r_d4_pa[i]);
                r_d5_car.pb[i] <= f_trunc30(r_d4_pb[i]);
            end
            r_d5_car.c <= r_d4_car.c;
            r_d5_car.r <= r_d4_car.r;
            r_d5_car.m <= r_d4_car.m;
            // coincident rays: |ca| reached one, no circle
            r_d5_car.dg <= r_d4_car.dg | (r_d4_sq[DEN_W-1:0] == (DEN_W'(1) << 60));
        end
    end

    // ------------------------------------------------------------------------
    // sine of the half angle, s = sqrt(den) in q30
    // ------------------------------------------------------------------------
    logic [SD_W-1:0] sd;
    t_car_c          r_dlc [SD_W];

    cfc_isqrt #(
        .IW (DEN_W)
    ) u_isqrt_den (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_d5_den),
        .o_root (sd)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dlc[0] <= r_d5_car;
            for (int k = 1; k < SD_W; k++) begin
                r_dlc[k] <= r_dlc[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // nine offsets: v * r / s for v in m, pa, pb
    // ------------------------------------------------------------------------
    logic [31:0]      sel_v  [9];
    logic [NUM_W-1:0] r_e1_num [9];
    logic [SD_W-1:0]  r_e1_sd;
    t_car_d           r_e1_car;
    logic [OQ_W-1:0]  oq  [9];
    logic [8:0]       oovf;
    t_car_d           r_dld [OQ_W];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sel_v[i]     = r_dlc[SD_W-1].m[i];
            sel_v[3 + i] = r_dlc[SD_W-1].pa[i];
            sel_v[6 + i] = r_dlc[SD_W-1].pb[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 9; j++) begin
                r_e1_num[j]     <= NUM_W'(62'(f_abs31(sel_v[j])) * 62'(r_dlc[SD_W-1].r));
                r_e1_car.neg[j] <= sel_v[j][31];
            end
            r_e1_sd     <= sd;
            r_e1_car.c  <= r_dlc[SD_W-1].c;
            r_e1_car.dg <= r_dlc[SD_W-1].dg;
        end
    end

    for (genvar j = 0; j < 9; j++) begin : g_off
        cfc_div #(
            .NW (NUM_W),
            .DW (SD_W),
            .QW (OQ_W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_e1_num[j]),
            .i_den (r_e1_sd),
            .o_quo (oq[j]),
            .o_ovf (oovf[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dld[0] <= r_e1_car;
            for (int k = 1; k < OQ_W; k++) begin
                r_dld[k] <= r_dld[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // signed offsets, then corner + offset with saturation into the output
    // register, or zero when degenerate; huge offsets clamp to 2^34, which saturates just the same
    // ------------------------------------------------------------------------
    logic signed [OQ_W+1:0] r_f1_off [9];
    t_car_d                 r_f1_car;
    logic [31:0]            r_out [9];
    logic                   r_out_dg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 9; j++) begin
                if (oovf[j]) begin
                    r_f1_off[j] <= r_dld[OQ_W-1].neg[j] ? -((OQ_W+2)'(1) << OQ_W)
                                                        : ((OQ_W+2)'(1) << OQ_W);
                end else begin
                    r_f1_off[j] <= r_dld[OQ_W-1].neg[j] ? -$signed((OQ_W+2)'(oq[j]))
                                                        : $signed((OQ_W+2)'(oq[j]));
                end
            end
            r_f1_car <= r_dld[OQ_W-1];

            for (int j = 0; j < 9; j++) begin
                r_out[j] <= r_f1_car.dg ? 32'd0
                          : f_sat32($signed({{5{r_f1_car.c[j % 3][31]}}, r_f1_car.c[j % 3]})
                                    + 37'(r_f1_off[j]));
            end
            r_out_dg <= r_f1_car.dg;
        end
    end

    assign o_centre_x       = r_out[0];
    assign o_centre_y       = r_out[1];
    assign o_centre_z       = r_out[2];
    assign o_touch_first_x  = r_out[3];
    assign o_touch_first_y  = r_out[4];
    assign o_touch_first_z  = r_out[5];
    assign o_touch_second_x = r_out[6];
    assign o_touch_second_y = r_out[7];
    assign o_touch_second_z = r_out[8];
    assign o_degenerate     = r_out_dg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `CFC_ASSERT_IMP(a_dg_zero, i_clk, i_rst_n, o_valid && o_degenerate,
        o_centre_x == 32'd0 && o_touch_first_y == 32'd0 && o_touch_second_z == 32'd0,
        "degenerate transaction with nonzero coordinates")
    `CFC_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !en, $stable(r_vld),
        "valid bits moved during a stall")
    `CFC_ASSERT_NXT(a_enter, i_clk, i_rst_n, en && i_valid, r_vld[0],
        "accepted transaction did not enter the pipeline")

endmodule
